@@ hdl/sdlp_pkg.sv @@
package sdlp_pkg;

  // Register map
  localparam int unsigned REG_COUNT = 2;
  localparam int unsigned REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_LONG_PRESS = 1'd1;
  localparam int unsigned CFG_BITS = 16;

  // Reset values of the registers
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

  // Status codes
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_CLOSED = 2'd1;
  localparam logic [1:0] STATUS_OPENED = 2'd2;
  localparam logic [1:0] STATUS_OPENED_LONG = 2'd3;

  // Input word: one poll
  typedef struct packed {
    logic [31:0] now_ms;
    logic        switch_on;
  } sdlp_in_t;

  // Output word: one result per poll
  typedef struct packed {
    logic [1:0] status;
    logic       changed;
    logic       stable_on;
  } sdlp_out_t;

  // Register values handed to the update logic
  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] long_press_ms;
  } sdlp_cfg_t;

endpackage

@@ hdl/sdlp_core.sv @@
module sdlp_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sdlp_pkg::sdlp_in_t  poll,
  input  sdlp_pkg::sdlp_cfg_t cfg,
  output sdlp_pkg::sdlp_out_t result
);
  import sdlp_pkg::*;

  logic                 raw_last;
  logic                 stable_level;
  logic                 long_flag;
  logic [TIME_BITS-1:0] deadline_ms;

  logic                 raw_last_next;
  logic                 stable_level_next;
  logic                 long_flag_next;
  logic [TIME_BITS-1:0] deadline_ms_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 nonneg;
  logic                 is_long;

  // Reduce or extend the timestamp to the time width
  assign now_t  = TIME_BITS'(poll.now_ms);
  assign diff   = now_t - deadline_ms;
  assign nonneg = ~diff[TIME_BITS-1];
  assign is_long = nonneg && (diff > TIME_BITS'(cfg.long_press_ms));

  // Evaluate one poll against the current state
  always_comb begin
    raw_last_next     = raw_last;
    stable_level_next = stable_level;
    long_flag_next    = long_flag;
    deadline_ms_next  = deadline_ms;
    result.status     = STATUS_NONE;
    result.changed    = 1'b0;
    if (poll.switch_on != raw_last) begin
      // Edge on the raw level: restart the debounce window
      if (!poll.switch_on) begin
        long_flag_next = is_long;
      end
      deadline_ms_next = now_t + TIME_BITS'(cfg.debounce_ms);
      raw_last_next    = poll.switch_on;
    end else if (nonneg && (poll.switch_on != stable_level)) begin
      // Level held past the deadline: report the change
      if (poll.switch_on) begin
        result.status = STATUS_CLOSED;
      end else if (long_flag) begin
        result.status = STATUS_OPENED_LONG;
      end else begin
        result.status = STATUS_OPENED;
      end
      stable_level_next = poll.switch_on;
      result.changed    = 1'b1;
    end
    result.stable_on = stable_level_next;
  end

  // Hold the switch state, advance on each poll
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last     <= 1'b0;
      stable_level <= 1'b0;
      long_flag    <= 1'b0;
      deadline_ms  <= '0;
    end else if (step) begin
      raw_last     <= raw_last_next;
      stable_level <= stable_level_next;
      long_flag    <= long_flag_next;
      deadline_ms  <= deadline_ms_next;
    end
  end

endmodule

@@ hdl/switch_debounce_long_press.sv @@
// An accepted input word is held in the input register; its result word is then registered on the output.
// Throughput: one word per cycle while out_ready does not stall the output; the state update sets this rate.
// Reset (rst, synchronous, active high): switch state cleared, both levels off,
// deadline zero, debounce_ms back to 50, long_press_ms back to 1000,
// both pipeline stages emptied.
module switch_debounce_long_press #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  sdlp_pkg::sdlp_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output sdlp_pkg::sdlp_out_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [sdlp_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [sdlp_pkg::CFG_BITS-1:0]          cfg_data
);
  import sdlp_pkg::*;

  sdlp_cfg_t cfg;
  sdlp_in_t  in_reg;
  logic      in_full;
  logic      out_advance;
  logic      step;
  sdlp_out_t result;

  // Output stage moves when empty or taken; input stage feeds it
  assign out_advance = !out_valid || out_ready;
  assign step        = in_full && out_advance;
  assign in_ready    = !in_full || out_advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DEBOUNCE_RESET;
      cfg.long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted word in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  sdlp_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .poll   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Register the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

@@ test/switch_debounce_long_press_tb.sv @@
`timescale 1ns / 100ps

module switch_debounce_long_press_tb;
  import sdlp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sdlp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdlp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_BITS-1:0] cfg_data = '0;

  switch_debounce_long_press dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Debouncer state and register copies
  logic [CFG_BITS-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic [CFG_BITS-1:0] long_press_cfg = LONG_PRESS_RESET;
  logic raw_level = 1'b0;
  logic stable_level = 1'b0;
  logic long_release = 1'b0;
  logic [31:0] settle_at = '0;

  sdlp_in_t pending_polls[$];
  sdlp_out_t expected_reports[$];
  int errors = 0;
  int idle_pct = 20;
  int send_gap = 0;
  int take_gap = 0;

  // Switch activity generator state
  logic [31:0] gen_time = '0;
  logic gen_level = 1'b0;
  logic gen_raw = 1'b0;
  logic [31:0] gen_changed_at = '0;
  int polls_left = 0;

  // Advance the debouncer by one poll and return its report
  function automatic sdlp_out_t debounce_poll(input sdlp_in_t w);
    logic [31:0] diff;
    sdlp_out_t r;
    diff = w.now_ms - settle_at;
    r = '0;
    r.status = STATUS_NONE;
    if (w.switch_on != raw_level) begin
      // on release, note whether the press outlasted the long-press time
      if (!w.switch_on) long_release = !diff[31] && diff > 32'(long_press_cfg);
      settle_at = w.now_ms + 32'(debounce_cfg);
      raw_level = w.switch_on;
    end else if (!diff[31] && w.switch_on != stable_level) begin
      if (w.switch_on) r.status = STATUS_CLOSED;
      else if (long_release) r.status = STATUS_OPENED_LONG;
      else r.status = STATUS_OPENED;
      stable_level = w.switch_on;
      r.changed = 1'b1;
    end
    r.stable_on = stable_level;
    return r;
  endfunction

  // Drive polls from the pending queue, predicting each accepted word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_reports.push_back(debounce_poll(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_polls.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= pending_polls.pop_front();
          in_valid <= 1'b1;
        end else begin
          // start an idle burst
          if (pending_polls.size() != 0) send_gap = $urandom_range(17);
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept reports with random stalls and compare against the oldest prediction
  always @(posedge clk) begin
    sdlp_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report word with no poll pending");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, out_data.changed);
            errors++;
          end
          if (out_data.stable_on !== want.stable_on) begin
            $error("stable_on: expected %0d, got %0d", want.stable_on, out_data.stable_on);
            errors++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        take_gap = $urandom_range(17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEBOUNCE) debounce_cfg = val;
    else long_press_cfg = val;
  endtask

  // Hold until every queued poll is sent and every report is back, then settle
  task automatic wait_drained();
    while (pending_polls.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_poll(input logic [31:0] t, input logic lvl);
    sdlp_in_t w;
    if (lvl != gen_raw) gen_changed_at = t;
    gen_raw = lvl;
    w.now_ms = t;
    w.switch_on = lvl;
    pending_polls.push_back(w);
    polls_left--;
  endtask

  // Queue bouncing presses and releases with random hold times, plus some noise
  task automatic queue_presses(input int count);
    int step_max;
    logic [31:0] target;
    step_max = debounce_cfg / 2 + 2;
    gen_time = $urandom;
    polls_left = count;
    while (polls_left > 0) begin
      if ($urandom_range(9) == 0) begin
        // stray poll at an arbitrary time
        queue_poll($urandom, 1'($urandom));
      end else begin
        gen_level = !gen_level;
        // contact bounce
        repeat ($urandom_range(3)) begin
          gen_time += $urandom_range(step_max / 4 + 1);
          queue_poll(gen_time, 1'($urandom));
        end
        // steady level
        repeat ($urandom_range(1, 8)) begin
          gen_time += $urandom_range(step_max);
          queue_poll(gen_time, gen_level);
        end
        if (gen_level) begin
          case ($urandom_range(3))
            0: begin
              // hold the press for a while, maybe past the long-press time
              gen_time += $urandom_range(2 * long_press_cfg + 2);
              queue_poll(gen_time, 1'b1);
            end
            1: begin
              // release right at the long-press boundary
              target = gen_changed_at + 32'(debounce_cfg) + 32'(long_press_cfg)
                       + $urandom_range(1);
              if ($signed(target - gen_time) >= 0) gen_time = target;
              queue_poll(gen_time, 1'b0);
            end
            default: ;
          endcase
        end
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] deb, input logic [CFG_BITS-1:0] lp,
                           input int pct, input int count);
    wait_drained();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lp);
    idle_pct = pct;
    queue_presses(count);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no change, close, short open, long open
    queue_poll(32'd0, 1'b0);
    queue_poll(32'd10, 1'b1);
    queue_poll(32'd30, 1'b1);
    queue_poll(32'd60, 1'b1);
    queue_poll(32'd100, 1'b0);
    queue_poll(32'd150, 1'b0);
    queue_poll(32'd200, 1'b1);
    queue_poll(32'd250, 1'b1);
    queue_poll(32'd2000, 1'b0);
    queue_poll(32'd2050, 1'b0);
    // Deadline wraps past zero; release half the time range later reads negative
    queue_poll(32'hFFFF_FFFF, 1'b1);
    queue_poll(32'd49, 1'b1);
    queue_poll(32'h8000_0031, 1'b0);
    queue_poll(32'h8000_0063, 1'b0);

    // Zero debounce and zero long-press time; the registers are written once all earlier reports arrive
    wait_drained();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_LONG_PRESS, 16'd0);
    queue_poll(32'd1000, 1'b1);
    queue_poll(32'd1000, 1'b1);
    queue_poll(32'd1001, 1'b0);
    queue_poll(32'd1001, 1'b0);
    queue_poll(32'd1005, 1'b1);
    queue_poll(32'd1005, 1'b1);
    queue_poll(32'd1005, 1'b0);
    queue_poll(32'd1005, 1'b0);

    // Random switch activity under several settings
    run_phase(16'hFFFF, 16'hFFFF, 30, 200);
    run_phase(16'd0, 16'd0, 25, 200);
    run_phase(16'($urandom), 16'($urandom), 0, 200);
    run_phase(16'd1, 16'hFFFF, 40, 200);
    run_phase(16'($urandom_range(200)), 16'($urandom_range(2000)), 15, 200);
    run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 0, 200);
    wait_drained();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
